/* rtl/abts_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// abts_pkg
// Shared constants for the array binary tree store: store size, field widths,
// status codes and the letter range accepted on insert.
// ----------------------------------------------------------------------------
package abts_pkg;

    // slots of the tree store, numbered from 1
    localparam int STORE_SLOTS = 256;

    // field widths
    localparam int IDX_W = 8;
    localparam int CNT_W = 8;
    localparam int ST_W  = 3;

    // only indices below 2**IDX_W can ever be filled
    localparam int MEM_DEPTH = (STORE_SLOTS < (1 << IDX_W)) ? STORE_SLOTS : (1 << IDX_W);
    localparam int MEM_AW    = $clog2(MEM_DEPTH);

    // wide enough for STORE_SLOTS at the top of its range
    localparam int LIM_W = 17;
    localparam logic [LIM_W-1:0] SLOT_LIM = LIM_W'(STORE_SLOTS);

    // actions
    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_DELETE = 1'b1;

    // status codes
    localparam logic [ST_W-1:0] ST_DONE         = 3'd0;
    localparam logic [ST_W-1:0] ST_BAD_INDEX    = 3'd1;
    localparam logic [ST_W-1:0] ST_BAD_LETTER   = 3'd2;
    localparam logic [ST_W-1:0] ST_PARENT_EMPTY = 3'd3;
    localparam logic [ST_W-1:0] ST_OCCUPIED     = 3'd4;
    localparam logic [ST_W-1:0] ST_SLOT_EMPTY   = 3'd5;
    localparam logic [ST_W-1:0] ST_HAS_CHILD    = 3'd6;

    // accepted letters
    localparam logic [7:0] LETTER_FIRST = 8'd65;
    localparam logic [7:0] LETTER_LAST  = 8'd90;

endpackage
`default_nettype wire

/* rtl/abts_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// abts_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module abts_ram #(
    parameter int DEPTH = 256,
    parameter int AW    = 8,
    parameter int DW    = 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [DW-1:0] i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

/* rtl/array_binary_tree_store_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// array_binary_tree_store_core
// Binary tree kept as a flat store of slots numbered from 1; inserts a node
// under a present parent or deletes a present leaf, one request at a time.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; its result word
// appears on o_status, o_node_count and o_max_index for exactly one cycle with
// o_valid high, and must be captured then. All store lookups go through one
// RAM read port with a registered output, one lookup at a time: a rejected
// request ends at its first failed check, an insert reads the parent, then the
// slot, a delete reads the slot and both children, and a delete of the highest
// used slot then walks the highest index down, reading each slot below it until
// one is filled or it reaches zero. The result strobe follows in the cycle after
// completion, while busy is already low. After reset the block clears all
// MEM_DEPTH (256) slots, one slot a cycle, with busy high, before any request.
// ----------------------------------------------------------------------------
module array_binary_tree_store_core (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       start,
    output logic                            busy,
    input  wire logic                       i_action,
    input  wire logic [abts_pkg::IDX_W-1:0] i_node_index,
    input  wire logic [7:0]                 i_letter,
    output logic                            o_valid,
    output logic [abts_pkg::ST_W-1:0]       o_status,
    output logic [abts_pkg::CNT_W-1:0]      o_node_count,
    output logic [abts_pkg::IDX_W-1:0]      o_max_index
);

    localparam int AW = abts_pkg::MEM_AW;

    localparam logic [2:0] S_CLEAR    = 3'd0;
    localparam logic [2:0] S_IDLE     = 3'd1;
    localparam logic [2:0] S_CHECK    = 3'd2;
    localparam logic [2:0] S_RD1      = 3'd3;
    localparam logic [2:0] S_RD2      = 3'd4;
    localparam logic [2:0] S_RD3      = 3'd5;
    localparam logic [2:0] S_WALK_RD  = 3'd6;
    localparam logic [2:0] S_WALK_CHK = 3'd7;

    logic [2:0]                  r_state,  n_state;
    logic [AW-1:0]               r_clr,    n_clr;
    logic                        r_action, n_action;
    logic [abts_pkg::IDX_W-1:0]  r_idx,    n_idx;
    logic [7:0]                  r_letter, n_letter;
    logic [abts_pkg::CNT_W-1:0]  r_count,  n_count;
    logic [abts_pkg::IDX_W-1:0]  r_top,    n_top;
    logic                        r_kid,    n_kid;

    logic                        r_out_valid;
    logic [abts_pkg::ST_W-1:0]   r_out_status;
    logic [abts_pkg::CNT_W-1:0]  r_out_count;
    logic [abts_pkg::IDX_W-1:0]  r_out_top;

    logic                        n_done;
    logic [abts_pkg::ST_W-1:0]   n_status;

    logic                        mem_we;
    logic [AW-1:0]               mem_waddr;
    logic                        mem_wdata;
    logic [AW-1:0]               mem_raddr;
    logic                        mem_rdata;

    logic                        idx_ok;
    logic [abts_pkg::IDX_W-1:0]  parent;
    logic [abts_pkg::IDX_W:0]    left_kid;
    logic [abts_pkg::IDX_W:0]    right_kid;
    logic [abts_pkg::IDX_W:0]    top_ext;

    // presence only: a filled slot always holds a nonzero letter
    abts_ram #(
        .DEPTH (abts_pkg::MEM_DEPTH),
        .AW    (AW),
        .DW    (1)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign idx_ok    = (r_idx != '0) &&
                       ({{(abts_pkg::LIM_W-abts_pkg::IDX_W){1'b0}}, r_idx} < abts_pkg::SLOT_LIM);
    assign parent    = r_idx >> 1;
    assign left_kid  = {r_idx, 1'b0};
    assign right_kid = {r_idx, 1'b1};
    assign top_ext   = {1'b0, r_top};

    always_comb begin
        n_state   = r_state;
        n_clr     = r_clr;
        n_action  = r_action;
        n_idx     = r_idx;
        n_letter  = r_letter;
        n_count   = r_count;
        n_top     = r_top;
        n_kid     = r_kid;
        n_done    = 1'b0;
        n_status  = abts_pkg::ST_DONE;
        mem_we    = 1'b0;
        mem_waddr = r_clr;
        mem_wdata = 1'b0;
        mem_raddr = r_idx[AW-1:0];

        case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                n_clr     = r_clr + 1'b1;
                if (r_clr == AW'(abts_pkg::MEM_DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_action = i_action;
                    n_idx    = i_node_index;
                    n_letter = i_letter;
                    n_state  = S_CHECK;
                end
            end
            S_CHECK: begin
                if (!idx_ok) begin
                    n_done   = 1'b1;
                    n_status = abts_pkg::ST_BAD_INDEX;
                    n_state  = S_IDLE;
                end else if (r_action == abts_pkg::ACT_INSERT) begin
                    if (r_letter < abts_pkg::LETTER_FIRST || r_letter > abts_pkg::LETTER_LAST) begin
                        n_done   = 1'b1;
                        n_status = abts_pkg::ST_BAD_LETTER;
                        n_state  = S_IDLE;
                    end else begin
                        mem_raddr = parent[AW-1:0];
                        n_state   = S_RD1;
                    end
                end else begin
                    if (r_idx > r_top) begin
                        n_done   = 1'b1;
                        n_status = abts_pkg::ST_SLOT_EMPTY;
                        n_state  = S_IDLE;
                    end else begin
                        mem_raddr = r_idx[AW-1:0];
                        n_state   = S_RD1;
                    end
                end
            end
            S_RD1: begin
                if (r_action == abts_pkg::ACT_INSERT) begin
                    // root has no parent to check
                    if (r_idx != abts_pkg::IDX_W'(1) && !mem_rdata) begin
                        n_done   = 1'b1;
                        n_status = abts_pkg::ST_PARENT_EMPTY;
                        n_state  = S_IDLE;
                    end else begin
                        mem_raddr = r_idx[AW-1:0];
                        n_state   = S_RD2;
                    end
                end else begin
                    if (!mem_rdata) begin
                        n_done   = 1'b1;
                        n_status = abts_pkg::ST_SLOT_EMPTY;
                        n_state  = S_IDLE;
                    end else begin
                        mem_raddr = left_kid[AW-1:0];
                        n_state   = S_RD2;
                    end
                end
            end
            S_RD2: begin
                if (r_action == abts_pkg::ACT_INSERT) begin
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                    if (mem_rdata) begin
                        n_status = abts_pkg::ST_OCCUPIED;
                    end else begin
                        mem_we    = 1'b1;
                        mem_waddr = r_idx[AW-1:0];
                        mem_wdata = 1'b1;
                        n_count   = r_count + 1'b1;
                        if (r_idx > r_top) begin
                            n_top = r_idx;
                        end
                    end
                end else begin
                    // children above the highest index count as absent
                    n_kid     = (left_kid <= top_ext) && mem_rdata;
                    mem_raddr = right_kid[AW-1:0];
                    n_state   = S_RD3;
                end
            end
            S_RD3: begin
                if (r_kid || ((right_kid <= top_ext) && mem_rdata)) begin
                    n_done   = 1'b1;
                    n_status = abts_pkg::ST_HAS_CHILD;
                    n_state  = S_IDLE;
                end else begin
                    mem_we    = 1'b1;
                    mem_waddr = r_idx[AW-1:0];
                    mem_wdata = 1'b0;
                    if (r_count != '0) begin
                        n_count = r_count - 1'b1;
                    end
                    if (r_idx == r_top) begin
                        n_top   = r_idx - 1'b1;
                        n_state = S_WALK_RD;
                    end else begin
                        n_done  = 1'b1;
                        n_state = S_IDLE;
                    end
                end
            end
            S_WALK_RD: begin
                if (r_top == '0) begin
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    mem_raddr = r_top[AW-1:0];
                    n_state   = S_WALK_CHK;
                end
            end
            S_WALK_CHK: begin
                if (mem_rdata) begin
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_top   = r_top - 1'b1;
                    n_state = S_WALK_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_count     <= '0;
            r_top       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_count     <= n_count;
            r_top       <= n_top;
            r_out_valid <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_action <= n_action;
        r_idx    <= n_idx;
        r_letter <= n_letter;
        r_kid    <= n_kid;
        if (n_done) begin
            r_out_status <= n_status;
            r_out_count  <= n_count;
            r_out_top    <= n_top;
        end
    end

    assign busy         = (r_state != S_IDLE);
    assign o_valid      = r_out_valid;
    assign o_status     = r_out_status;
    assign o_node_count = r_out_count;
    assign o_max_index  = r_out_top;

`ifndef SYNTHESIS
    // every request leaves S_IDLE for S_CHECK before it can end, so strobes never touch
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe high in two cycles in a row");

    a_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted word did not raise busy");

    // nodes sit at slots 1..top, so the count cannot pass the top index
    a_count_le_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_count <= r_top))
        else $error("node count above highest index");

    a_empty_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && r_count == '0) |-> (r_top == '0))
        else $error("empty tree with nonzero highest index");

    a_walk_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK_CHK) |=> (r_top <= $past(r_top)))
        else $error("top index grew during walk");
`endif

endmodule
`default_nettype wire

/* verif/abts_checker.sv */
// ----------------------------------------------------------------------------
// abts_checker
// Watches the request and result channels of the tree store core. It keeps
// its own copy of the tree, works out each result word when a request is
// taken, and compares every result word field by field in arrival order.
// ----------------------------------------------------------------------------
module abts_checker (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic                       i_busy,
    input  wire logic                       i_action,
    input  wire logic [abts_pkg::IDX_W-1:0] i_node_index,
    input  wire logic [7:0]                 i_letter,
    input  wire logic                       i_valid,
    input  wire logic [abts_pkg::ST_W-1:0]  i_status,
    input  wire logic [abts_pkg::CNT_W-1:0] i_node_count,
    input  wire logic [abts_pkg::IDX_W-1:0] i_max_index,
    output int                              o_fail_count,
    output int                              o_pending,
    output int                              o_checked,
    output bit [7:0]                        o_status_seen
);

    typedef struct packed {
        logic [abts_pkg::ST_W-1:0]  status;
        logic [abts_pkg::CNT_W-1:0] node_count;
        logic [abts_pkg::IDX_W-1:0] max_index;
    } t_tree_result;

    logic [7:0]                 tree_slots [0:abts_pkg::MEM_DEPTH-1];
    logic [abts_pkg::CNT_W-1:0] node_total;
    logic [abts_pkg::IDX_W-1:0] top_slot;
    t_tree_result               tree_results_q [$];

    // slots past the store or above the top index hold nothing
    function automatic bit slot_taken(input int k);
        if (k == 0 || k >= abts_pkg::STORE_SLOTS || k > top_slot)
            return 1'b0;
        return tree_slots[k] != 8'd0;
    endfunction

    task automatic apply_tree_request(
        input  logic                       act,
        input  logic [abts_pkg::IDX_W-1:0] idx,
        input  logic [7:0]                 letter,
        output t_tree_result               res
    );
        logic [abts_pkg::ST_W-1:0] st;
        if (idx == 0 || idx >= abts_pkg::STORE_SLOTS) begin
            st = abts_pkg::ST_BAD_INDEX;
        end else if (act == abts_pkg::ACT_INSERT) begin
            if (letter < abts_pkg::LETTER_FIRST || letter > abts_pkg::LETTER_LAST) begin
                st = abts_pkg::ST_BAD_LETTER;
            end else if (idx != 1 && tree_slots[idx >> 1] == 8'd0) begin
                st = abts_pkg::ST_PARENT_EMPTY;
            end else if (tree_slots[idx] != 8'd0) begin
                st = abts_pkg::ST_OCCUPIED;
            end else begin
                st = abts_pkg::ST_DONE;
                tree_slots[idx] = letter;
                node_total = node_total + 1'b1;
                if (idx > top_slot)
                    top_slot = idx;
            end
        end else begin
            if (idx > top_slot || tree_slots[idx] == 8'd0) begin
                st = abts_pkg::ST_SLOT_EMPTY;
            end else if (slot_taken(2 * idx) || slot_taken(2 * idx + 1)) begin
                st = abts_pkg::ST_HAS_CHILD;
            end else begin
                st = abts_pkg::ST_DONE;
                tree_slots[idx] = 8'd0;
                if (node_total > 0)
                    node_total = node_total - 1'b1;
                // trim the top index down past empty slots
                if (idx == top_slot) begin
                    while (top_slot > 0 && tree_slots[top_slot] == 8'd0)
                        top_slot = top_slot - 1'b1;
                end
            end
        end
        res.status     = st;
        res.node_count = node_total;
        res.max_index  = top_slot;
    endtask

    always @(posedge i_clk) begin
        t_tree_result want;
        t_tree_result got;
        if (!i_rst_n) begin
            for (int k = 0; k < abts_pkg::MEM_DEPTH; k++)
                tree_slots[k] = 8'd0;
            node_total = '0;
            top_slot   = '0;
            tree_results_q.delete();
        end else begin
            if (i_valid) begin
                got.status     = i_status;
                got.node_count = i_node_count;
                got.max_index  = i_max_index;
                if (tree_results_q.size() == 0) begin
                    o_fail_count++;
                    $display("%0t: unexpected result word, expected none, actual %0d/%0d/%0d",
                             $time, got.status, got.node_count, got.max_index);
                end else begin
                    want = tree_results_q.pop_front();
                    o_checked++;
                    o_status_seen[want.status] = 1'b1;
                    if (got.status !== want.status) begin
                        o_fail_count++;
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, got.status);
                    end
                    if (got.node_count !== want.node_count) begin
                        o_fail_count++;
                        $display("%0t: node_count expected %0d actual %0d",
                                 $time, want.node_count, got.node_count);
                    end
                    if (got.max_index !== want.max_index) begin
                        o_fail_count++;
                        $display("%0t: max_index expected %0d actual %0d",
                                 $time, want.max_index, got.max_index);
                    end
                end
            end
            if (i_start && !i_busy) begin
                apply_tree_request(i_action, i_node_index, i_letter, want);
                tree_results_q.push_back(want);
            end
        end
        o_pending = tree_results_q.size();
    end

endmodule

/* verif/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Drives the tree store core with directed corner requests, then with random
// build, churn and teardown sequences, edge-path walks and noise, while abts_checker predicts
// and compares every result word.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int ITEM_TARGET    = 850;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int END_CYCLES     = 20;

    logic                       i_clk        = 1'b0;
    logic                       i_rst_n      = 1'b0;
    logic                       start        = 1'b0;
    logic                       busy;
    logic                       i_action     = abts_pkg::ACT_INSERT;
    logic [abts_pkg::IDX_W-1:0] i_node_index = '0;
    logic [7:0]                 i_letter     = 8'd0;
    logic                       o_valid;
    logic [abts_pkg::ST_W-1:0]  o_status;
    logic [abts_pkg::CNT_W-1:0] o_node_count;
    logic [abts_pkg::IDX_W-1:0] o_max_index;

    int     fail_count;
    int     pending;
    int     checked;
    bit [7:0] status_seen;
    int     items_sent;
    int     stall_cycles;
    bit     quiet;

    array_binary_tree_store_core i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_action     (i_action),
        .i_node_index (i_node_index),
        .i_letter     (i_letter),
        .o_valid      (o_valid),
        .o_status     (o_status),
        .o_node_count (o_node_count),
        .o_max_index  (o_max_index)
    );

    abts_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_busy        (busy),
        .i_action      (i_action),
        .i_node_index  (i_node_index),
        .i_letter      (i_letter),
        .i_valid       (o_valid),
        .i_status      (o_status),
        .i_node_count  (o_node_count),
        .i_max_index   (o_max_index),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_checked     (checked),
        .o_status_seen (status_seen)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // mostly uppercase letters, the rest any byte
    function automatic logic [7:0] pick_letter(input int bad_pct);
        if ($urandom_range(0, 99) < bad_pct)
            return 8'($urandom_range(0, 255));
        return 8'($urandom_range(abts_pkg::LETTER_FIRST, abts_pkg::LETTER_LAST));
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_word(input logic act, input logic [abts_pkg::IDX_W-1:0] idx,
                             input logic [7:0] letter);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start        <= 1'b1;
        i_action     <= act;
        i_node_index <= idx;
        i_letter     <= letter;
        do @(posedge i_clk); while (busy);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        start <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
    endtask

    task automatic build_range(input int n);
        for (int i = 1; i <= n; i++)
            send_word(abts_pkg::ACT_INSERT, abts_pkg::IDX_W'(i), pick_letter(12));
    endtask

    task automatic churn(input int n, input int m);
        int idx;
        repeat (m) begin
            idx = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(1, n);
            send_word(1'($urandom_range(0, 1)), abts_pkg::IDX_W'(idx), pick_letter(15));
        end
    endtask

    // children sit above parents, so a descending pass removes leaves first
    task automatic teardown(input int n);
        for (int i = n; i >= 1; i--)
            send_word(abts_pkg::ACT_DELETE, abts_pkg::IDX_W'(i), 8'($urandom_range(0, 255)));
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no word moved for %0d cycles", $time, stall_cycles);
            $display("array_binary_tree_store_core: mismatch");
            $finish;
        end
    end

    initial begin
        int  n;
        bit  full_done;
        full_done = 1'b0;
        quiet     = 1'b0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed corners
        send_word(abts_pkg::ACT_DELETE, 8'd1, 8'd0);     // delete from empty tree
        send_word(abts_pkg::ACT_INSERT, 8'd0, abts_pkg::LETTER_FIRST);   // index zero
        send_word(abts_pkg::ACT_DELETE, 8'd0, 8'hFF);
        send_word(abts_pkg::ACT_INSERT, 8'd0, 8'd0);     // bad index wins over bad letter
        send_word(abts_pkg::ACT_INSERT, 8'd2, abts_pkg::LETTER_LAST);    // no root yet
        send_word(abts_pkg::ACT_INSERT, 8'd1, 8'(abts_pkg::LETTER_FIRST - 1));
        send_word(abts_pkg::ACT_INSERT, 8'd1, 8'(abts_pkg::LETTER_LAST + 1));
        send_word(abts_pkg::ACT_INSERT, 8'd1, abts_pkg::LETTER_FIRST);
        send_word(abts_pkg::ACT_INSERT, 8'd1, abts_pkg::LETTER_LAST);    // root taken
        send_word(abts_pkg::ACT_INSERT, 8'd4, 8'hFF);    // bad letter wins over parent empty
        send_word(abts_pkg::ACT_INSERT, 8'd255, 8'd81);  // deep slot, parent empty
        send_word(abts_pkg::ACT_DELETE, 8'd255, 8'd0);   // above the top index
        send_word(abts_pkg::ACT_INSERT, 8'd2, abts_pkg::LETTER_LAST);
        send_word(abts_pkg::ACT_INSERT, 8'd3, 8'd77);
        send_word(abts_pkg::ACT_INSERT, 8'd3, 8'd78);
        send_word(abts_pkg::ACT_DELETE, 8'd1, 8'd0);     // root still has children
        send_word(abts_pkg::ACT_DELETE, 8'd3, 8'd0);
        send_word(abts_pkg::ACT_DELETE, 8'd2, 8'd0);
        send_word(abts_pkg::ACT_DELETE, 8'd1, 8'd0);
        send_word(abts_pkg::ACT_DELETE, 8'd1, 8'd0);
        drain_results();

        while (items_sent < ITEM_TARGET) begin
            quiet = ($urandom_range(0, 3) == 0);
            if (!full_done && items_sent > 100) begin
                // an insert sent to every slot once, then churn, then every slot emptied
                full_done = 1'b1;
                build_range(abts_pkg::STORE_SLOTS - 1);
                churn(abts_pkg::STORE_SLOTS - 1, 30);
                teardown(abts_pkg::STORE_SLOTS - 1);
            end else begin
                case ($urandom_range(0, 5))
                    0: begin
                        // the left and right edge paths down to 128 and 255, then deletes that walk the top index down
                        for (int k = 0; k < 8; k++) begin
                            send_word(abts_pkg::ACT_INSERT, abts_pkg::IDX_W'(1 << k),
                                      pick_letter(0));
                            send_word(abts_pkg::ACT_INSERT, abts_pkg::IDX_W'((2 << k) - 1),
                                      pick_letter(0));
                        end
                        for (int k = 7; k >= 1; k--)
                            send_word(abts_pkg::ACT_DELETE, abts_pkg::IDX_W'((2 << k) - 1),
                                      8'd0);
                        for (int k = 7; k >= 0; k--)
                            send_word(abts_pkg::ACT_DELETE, abts_pkg::IDX_W'(1 << k), 8'd0);
                    end
                    1: begin
                        repeat (12)
                            send_word(1'($urandom_range(0, 1)),
                                      abts_pkg::IDX_W'($urandom_range(0, 255)),
                                      8'($urandom_range(0, 255)));
                    end
                    default: begin
                        n = $urandom_range(2, 40);
                        build_range(n);
                        churn(n, $urandom_range(5, 40));
                        teardown(n);
                    end
                endcase
            end
            if ($urandom_range(0, 2) == 0)
                drain_results();
        end

        drain_results();
        repeat (END_CYCLES) @(negedge i_clk);
        $display("sent %0d requests, checked %0d result words, status codes seen %b",
                 items_sent, checked, status_seen[6:0]);
        if (fail_count == 0)
            $display("array_binary_tree_store_core: match");
        else
            $display("array_binary_tree_store_core: mismatch");
        $finish;
    end

endmodule
